// ===== rtl/elga_pkg.sv =====
// Shared types, codes and constants for the embedding lookup / gradient accumulate unit.
package elga_pkg;

    localparam int VAL_W      = 32;
    localparam int ROW_W      = 16;
    localparam int ELEM_W     = 6;
    localparam int OP_W       = 2;
    localparam int ROWS_CFG_W = 11;
    localparam int DIM_CFG_W  = 7;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam int DEF_MAX_ROWS = 1024;
    localparam int DEF_MAX_DIM  = 64;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RST = 11'd1024;
    localparam logic [DIM_CFG_W-1:0]  DIM_RST  = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_DIM  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_WR_WEIGHT = 2'd0,
        OP_LOOKUP    = 2'd1,
        OP_ACC_GRAD  = 2'd2,
        OP_RD_GRAD   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ACC_WB,
        ST_RD_OUT,
        ST_LK_OUT
    } state_t;

    typedef struct packed {
        logic capture;   // load the item registers
        logic clr_wr;    // zero one gradient entry, advance sweep
        logic wt_wr;     // write weight element
        logic gr_rd;     // read gradient element
        logic gr_wr;     // write back saturated sum
        logic wt_rd;     // read weight element of the row
        logic lk_emit;   // load output from weight data, step element
        logic rd_emit;   // load output from gradient data
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        op_t  op;
        logic item_ok;
        logic lk_last;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/elga_in_if.sv =====
// Input channel: one operation per transfer.
interface elga_in_if;
    logic                                valid;
    logic                                ready;
    logic [elga_pkg::OP_W-1:0]           opcode;
    logic signed [elga_pkg::ROW_W-1:0]   row_index;
    logic [elga_pkg::ELEM_W-1:0]         elem_index;
    logic signed [elga_pkg::VAL_W-1:0]   value_in;

    modport source (output valid, output opcode, output row_index, output elem_index,
                    output value_in, input ready);
    modport sink   (input valid, input opcode, input row_index, input elem_index,
                    input value_in, output ready);
endinterface

// ===== rtl/elga_out_if.sv =====
// Result channel: one element per transfer.
interface elga_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [elga_pkg::VAL_W-1:0]   value_out;
    logic [elga_pkg::ELEM_W-1:0]         elem_pos;
    logic                                row_valid;
    logic                                last;

    modport source (output valid, output value_out, output elem_pos, output row_valid,
                    output last, input ready);
    modport sink   (input valid, input value_out, input elem_pos, input row_valid,
                    input last, output ready);
endinterface

// ===== rtl/elga_ctrl.sv =====
// Sequencing state machine for clear sweep and the four operations.
module elga_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  elga_pkg::stat_t stat,
    output logic            in_ready,
    output elga_pkg::cmd_t  cmd
);
    import elga_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (stat.op)
                    OP_WR_WEIGHT: state_next = ST_IDLE;
                    OP_LOOKUP:    state_next = ST_LK_OUT;
                    OP_ACC_GRAD:  state_next = stat.item_ok ? ST_ACC_WB : ST_IDLE;
                    OP_RD_GRAD:   state_next = ST_RD_OUT;
                    default:      state_next = ST_IDLE;
                endcase
            end
            ST_ACC_WB:
                state_next = ST_IDLE;
            ST_RD_OUT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            ST_LK_OUT:
            begin
                if (stat.out_free && stat.lk_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
                cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                case (stat.op)
                    OP_WR_WEIGHT: cmd.wt_wr = stat.item_ok;
                    OP_LOOKUP:    cmd.wt_rd = 1'b1;
                    OP_ACC_GRAD:  cmd.gr_rd = stat.item_ok;
                    OP_RD_GRAD:   cmd.gr_rd = stat.item_ok;
                    default:      cmd.gr_rd = 1'b0;
                endcase
            end
            ST_ACC_WB:
                cmd.gr_wr = 1'b1;
            ST_RD_OUT:
                cmd.rd_emit = stat.out_free;
            ST_LK_OUT:
            begin
                cmd.lk_emit = stat.out_free;
                // fetch the next element while this one goes out
                cmd.wt_rd   = stat.out_free && !stat.lk_last;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

// ===== rtl/elga_dp.sv =====
// Datapath: item registers, weight and gradient memories, saturating adder, result register.
module elga_dp #(
    parameter int MAX_ROWS = elga_pkg::DEF_MAX_ROWS,
    parameter int MAX_DIM  = elga_pkg::DEF_MAX_DIM
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  elga_pkg::cmd_t                        cmd,
    output elga_pkg::stat_t                       stat,
    input  logic [elga_pkg::ROWS_CFG_W-1:0]       rows_cfg,
    input  logic [elga_pkg::DIM_CFG_W-1:0]        dim_cfg,
    input  logic [elga_pkg::OP_W-1:0]             in_opcode,
    input  logic signed [elga_pkg::ROW_W-1:0]     in_row_index,
    input  logic [elga_pkg::ELEM_W-1:0]           in_elem_index,
    input  logic signed [elga_pkg::VAL_W-1:0]     in_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [elga_pkg::VAL_W-1:0]     out_value,
    output logic [elga_pkg::ELEM_W-1:0]           out_elem_pos,
    output logic                                  out_row_valid,
    output logic                                  out_last
);
    import elga_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = AW + ELEM_W + 1;
    localparam int PW    = ROW_W + DIM_CFG_W - 1;
    localparam int RCW   = ROW_W + 1;
    localparam logic [RCW-1:0]       MaxRowsC = RCW'(MAX_ROWS);
    localparam logic [DIM_CFG_W-1:0] MaxDimC  = DIM_CFG_W'(MAX_DIM);
    localparam logic [AW-1:0]        LastAddr = AW'(DEPTH - 1);

    logic [VAL_W-1:0] weight_mem [DEPTH];
    logic [VAL_W-1:0] grad_mem   [DEPTH];

    op_t               op_reg;
    logic              row_ok_reg;
    logic              elem_ok_reg;
    logic [ELEM_W-1:0] elem_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [AW-1:0]     base_reg;
    logic [ELEM_W-1:0] cnt_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [VAL_W-1:0]  wq_reg;
    logic [VAL_W-1:0]  gq_reg;

    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [ELEM_W-1:0] out_pos_reg;
    logic              out_rv_reg;
    logic              out_last_reg;

    logic [RCW-1:0]       rows_eff;
    logic [DIM_CFG_W-1:0] dim_eff;
    logic                 in_row_ok;
    logic                 in_elem_ok;
    logic [PW-1:0]        in_base;
    logic                 item_ok;
    logic [AW-1:0]        item_addr;
    logic [ELEM_W-1:0]    lk_elem;
    logic [AW-1:0]        lk_addr;
    logic                 lk_last;
    logic [VAL_W:0]       acc_sum;
    logic [VAL_W-1:0]     acc_sat;
    logic                 out_free;

    always_comb
    begin
        rows_eff = ({{(RCW-ROWS_CFG_W){1'b0}}, rows_cfg} > MaxRowsC)
                 ? MaxRowsC : {{(RCW-ROWS_CFG_W){1'b0}}, rows_cfg};
        if (dim_cfg == '0)
            dim_eff = DIM_CFG_W'(1);
        else if (dim_cfg > MaxDimC)
            dim_eff = MaxDimC;
        else
            dim_eff = dim_cfg;
    end

    assign in_row_ok  = !in_row_index[ROW_W-1]
                      && ({2'b00, in_row_index[ROW_W-2:0]} < rows_eff);
    assign in_elem_ok = ({1'b0, in_elem_index} < dim_eff);
    assign in_base    = PW'(in_row_index[ROW_W-2:0]) * PW'(MAX_DIM);

    assign item_ok   = row_ok_reg && elem_ok_reg;
    assign item_addr = item_ok ? AW'(SW'(base_reg) + SW'(elem_reg)) : '0;
    assign lk_elem   = cmd.lk_emit ? (cnt_reg + ELEM_W'(1)) : cnt_reg;
    assign lk_addr   = row_ok_reg ? AW'(SW'(base_reg) + SW'(lk_elem)) : '0;
    assign lk_last   = (({1'b0, cnt_reg} + DIM_CFG_W'(1)) == dim_eff);

    // saturate when both operands agree in sign and the sum does not
    assign acc_sum = {gq_reg[VAL_W-1], gq_reg} + {value_reg[VAL_W-1], value_reg};
    always_comb
    begin
        if (acc_sum[VAL_W] != acc_sum[VAL_W-1])
            acc_sat = acc_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        else
            acc_sat = acc_sum[VAL_W-1:0];
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= op_t'(in_opcode);
            row_ok_reg  <= in_row_ok;
            elem_ok_reg <= in_elem_ok;
            elem_reg    <= in_elem_index;
            value_reg   <= in_value;
            base_reg    <= AW'(in_base);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.capture)
                cnt_reg <= '0;
            else if (cmd.lk_emit)
                cnt_reg <= cnt_reg + ELEM_W'(1);
            if (cmd.clr_wr)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wt_wr)
            weight_mem[item_addr] <= value_reg;
        if (cmd.wt_rd)
            wq_reg <= weight_mem[lk_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            grad_mem[clr_cnt_reg] <= '0;
        else if (cmd.gr_wr)
            grad_mem[item_addr] <= acc_sat;
        if (cmd.gr_rd)
            gq_reg <= grad_mem[item_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.lk_emit || cmd.rd_emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lk_emit)
        begin
            out_value_reg <= row_ok_reg ? wq_reg : '0;
            out_pos_reg   <= cnt_reg;
            out_rv_reg    <= row_ok_reg;
            out_last_reg  <= lk_last;
        end
        else if (cmd.rd_emit)
        begin
            out_value_reg <= item_ok ? gq_reg : '0;
            out_pos_reg   <= elem_reg;
            out_rv_reg    <= item_ok;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_elem_pos  = out_pos_reg;
    assign out_row_valid = out_rv_reg;
    assign out_last      = out_last_reg;

    always_comb
    begin
        stat.clr_done = (clr_cnt_reg == LastAddr);
        stat.op       = op_reg;
        stat.item_ok  = item_ok;
        stat.lk_last  = lk_last;
        stat.out_free = out_free;
    end

endmodule

// ===== rtl/embedding_lookup_grad_accumulate_unit.sv =====
// Top level: configuration registers, controller and datapath.
//
// Embedding table unit. Operations arrive on in_ch (valid/ready); results leave on
// out_ch (valid/ready) through a result register, so a new operation is taken while
// a finished result still waits for the receiver. Rows and elements per row are set
// through the APB port (rows_in_use at 0x0, dim_in_use at 0x4); the user must write
// them only when idle; the block does not enforce it. Steps, one item at a time:
//   write weight        capture, then write
//   accumulate gradient capture, read, saturating add, write back on one port pair
//   read gradient       capture, read, then load the result register when it is free
//   lookup              capture, first memory read, then one element per cycle
//                       as long as the receiver takes every transfer
// The weight memory read port sets the lookup rate; the gradient memory's single
// read and write port sets the accumulate rate.
// After reset all MAX_ROWS * MAX_DIM gradient entries are zeroed, one per cycle
// (65536 at the defaults); in_ch.ready stays low until then. Weight entries
// hold nothing defined until written. When the receiver stalls, the result register
// holds its transfer and a lookup waits element by element; nothing is dropped.
module embedding_lookup_grad_accumulate_unit #(
    parameter int MAX_ROWS = elga_pkg::DEF_MAX_ROWS,
    parameter int MAX_DIM  = elga_pkg::DEF_MAX_DIM
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [elga_pkg::PADDR_W-1:0]   paddr,
    input  logic [elga_pkg::PDATA_W-1:0]   pwdata,
    output logic [elga_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    elga_in_if.sink                        in_ch,
    elga_out_if.source                     out_ch
);
    import elga_pkg::*;

    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [DIM_CFG_W-1:0]  dim_reg;
    logic                  cfg_wr;
    cmd_t                  cmd;
    stat_t                 stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RST;
            dim_reg  <= DIM_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_DIM)
                dim_reg <= pwdata[DIM_CFG_W-1:0];
            else
                rows_reg <= pwdata[ROWS_CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ROWS) ? PDATA_W'(rows_reg) : PDATA_W'(dim_reg);

    elga_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .stat     (stat),
        .in_ready (in_ch.ready),
        .cmd      (cmd)
    );

    elga_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_DIM  (MAX_DIM)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .rows_cfg      (rows_reg),
        .dim_cfg       (dim_reg),
        .in_opcode     (in_ch.opcode),
        .in_row_index  (in_ch.row_index),
        .in_elem_index (in_ch.elem_index),
        .in_value      (in_ch.value_in),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_value     (out_ch.value_out),
        .out_elem_pos  (out_ch.elem_pos),
        .out_row_valid (out_ch.row_valid),
        .out_last      (out_ch.last)
    );

endmodule

// ===== rtl/elga_chk.sv =====
// Port-level checks for the embedding unit, bound to the top level.
module elga_chk (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [elga_pkg::VAL_W-1:0]  out_value,
    input  logic [elga_pkg::ELEM_W-1:0]        out_elem_pos,
    input  logic                               out_row_valid,
    input  logic                               out_last
);
    import elga_pkg::*;

    // one operation at a time: busy in the cycle after an input transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken in the cycle after a transfer");

    // out-of-range results carry zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_row_valid |-> out_value == '0)
        else $error("result for out-of-range row is not zero");

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_elem_pos)
                                   && $stable(out_row_valid) && $stable(out_last))
        else $error("result changed while stalled");

endmodule

bind embedding_lookup_grad_accumulate_unit elga_chk u_elga_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_value     (out_ch.value_out),
    .out_elem_pos  (out_ch.elem_pos),
    .out_row_valid (out_ch.row_valid),
    .out_last      (out_ch.last)
);
